// File: hdl/uart_8250_register_file_assert.svh
// Assertion macros for the UART register block checker.
// Both sample on aclk; the first is disabled while aresetn is low.
`ifndef UART_8250_REGISTER_FILE_ASSERT_SVH
`define UART_8250_REGISTER_FILE_ASSERT_SVH

`define URF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`define URF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/urf_pkg.sv
// Types, codes and constants for the UART register block.
// No dependencies; imported by the RTL modules, the checker and the bench.
package urf_pkg;

    // item commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // register offsets
    localparam logic [2:0] OFS_DATA = 3'd0;
    localparam logic [2:0] OFS_IER  = 3'd1;
    localparam logic [2:0] OFS_IIR  = 3'd2;
    localparam logic [2:0] OFS_LCR  = 3'd3;
    localparam logic [2:0] OFS_MCR  = 3'd4;
    localparam logic [2:0] OFS_LSR  = 3'd5;
    localparam logic [2:0] OFS_MSR  = 3'd6;
    localparam logic [2:0] OFS_SCR  = 3'd7;

    // which configuration register a write changed
    localparam logic [2:0] TOUCH_NONE = 3'd0;
    localparam logic [2:0] TOUCH_DIV  = 3'd1;
    localparam logic [2:0] TOUCH_IER  = 3'd2;
    localparam logic [2:0] TOUCH_LCR  = 3'd3;
    localparam logic [2:0] TOUCH_MCR  = 3'd4;

    // pending flag bit positions
    localparam int PEND_RX  = 0;
    localparam int PEND_TX  = 1;
    localparam int PEND_MSR = 2;
    localparam int PEND_LSR = 3;

    // IER bits
    localparam int IER_RX  = 0;
    localparam int IER_TX  = 1;
    localparam int IER_LSR = 2;

    localparam int LCR_DLAB = 7;
    localparam int MCR_LOOP = 4;

    localparam logic [7:0]  IIR_NONE    = 8'h01;
    localparam logic [7:0]  IIR_TX      = 8'h02;
    localparam logic [7:0]  IIR_RX      = 8'h04;
    localparam logic [7:0]  IIR_LSR     = 8'h06;
    localparam logic [7:0]  LSR_DATA    = 8'h61;
    localparam logic [7:0]  LSR_EMPTY   = 8'h60;
    localparam logic [7:0]  UNMAPPED    = 8'hFF;
    localparam logic [15:0] DIV_RESET   = 16'd12;
    localparam logic [7:0]  MSR_RESET   = 8'h30;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raise;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] config_touched;
        logic       rx_taken;
        logic       rx_empty;
    } urf_result_t;

    // data bits kept for word length LCR[1:0]
    function automatic logic [7:0] word_mask(input logic [1:0] wl);
        logic [7:0] m;
        unique case (wl)
            2'd0: m = 8'h1F;
            2'd1: m = 8'h3F;
            2'd2: m = 8'h7F;
            2'd3: m = 8'hFF;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/urf_core.sv
// UART register state and the per-item update logic.
// Depends on urf_pkg. Outside reset, state changes only when step_en is high.
module urf_core
    import urf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [1:0]  cmd,
    input  logic [2:0]  reg_offset,
    input  logic [7:0]  data_byte,
    output urf_result_t result
);

    logic [15:0] divisor_reg, divisor_next;
    logic [7:0]  ien_reg, ien_next;
    logic [7:0]  lcr_reg, lcr_next;
    logic [7:0]  mcr_reg, mcr_next;
    logic [7:0]  msr_reg;
    logic [7:0]  msr_last_reg, msr_last_next;
    logic [3:0]  pend_reg, pend_next;
    logic        rx_full_reg, rx_full_next;
    logic [7:0]  rx_byte_reg, rx_byte_next;

    always_comb begin
        logic [7:0] masked;
        logic [7:0] diff;
        logic       dlab;
        logic       irq;

        divisor_next  = divisor_reg;
        ien_next      = ien_reg;
        lcr_next      = lcr_reg;
        mcr_next      = mcr_reg;
        msr_last_next = msr_last_reg;
        pend_next     = pend_reg;
        rx_full_next  = rx_full_reg;
        rx_byte_next  = rx_byte_reg;

        dlab   = lcr_reg[LCR_DLAB];
        masked = word_mask(lcr_reg[1:0]) & data_byte;
        diff   = msr_reg ^ msr_last_reg;
        irq    = 1'b0;

        result.read_data      = 8'h00;
        result.tx_valid       = 1'b0;
        result.tx_byte        = 8'h00;
        result.config_touched = TOUCH_NONE;
        result.rx_taken       = 1'b0;

        unique case (cmd)
            CMD_READ: begin
                unique case (reg_offset)
                    OFS_DATA: begin
                        if (dlab) begin
                            result.read_data = divisor_reg[7:0];
                        end else begin
                            rx_full_next        = 1'b0;
                            pend_next[PEND_RX]  = 1'b0;
                            if (ien_reg[IER_LSR]) begin
                                pend_next[PEND_LSR] = 1'b1;
                                irq                 = 1'b1;
                            end
                            result.read_data = rx_byte_reg;
                            result.rx_taken  = 1'b1;
                        end
                    end
                    OFS_IER: result.read_data = dlab ? divisor_reg[15:8] : ien_reg;
                    OFS_IIR: begin
                        // TX has top priority and clears on read
                        priority if (pend_reg[PEND_TX]) begin
                            result.read_data   = IIR_TX;
                            pend_next[PEND_TX] = 1'b0;
                        end else if (pend_reg[PEND_RX]) begin
                            result.read_data = IIR_RX;
                        end else if (pend_reg[PEND_LSR]) begin
                            result.read_data = IIR_LSR;
                        end else if (pend_reg == 4'd0) begin
                            result.read_data = IIR_NONE;
                        end else begin
                            result.read_data = 8'h00;   // only MSR pending
                        end
                        irq = (pend_next != 4'd0);
                    end
                    OFS_LCR: result.read_data = lcr_reg;
                    OFS_MCR: result.read_data = mcr_reg;
                    OFS_LSR: begin
                        pend_next[PEND_LSR] = 1'b0;
                        result.read_data    = rx_full_reg ? LSR_DATA : LSR_EMPTY;
                    end
                    OFS_MSR: begin
                        result.read_data = {msr_reg[7:4], diff[7], 1'b0, diff[5], diff[4]};
                        msr_last_next      = msr_reg;
                        pend_next[PEND_MSR] = 1'b0;
                    end
                    OFS_SCR: result.read_data = UNMAPPED;
                    default: result.read_data = UNMAPPED;
                endcase
            end
            CMD_WRITE: begin
                unique case (reg_offset)
                    OFS_DATA: begin
                        if (dlab) begin
                            divisor_next[7:0]     = data_byte;
                            result.config_touched = TOUCH_DIV;
                        end else if (mcr_reg[MCR_LOOP]) begin
                            rx_byte_next = masked;
                            rx_full_next = 1'b1;
                            if (ien_reg[IER_RX]) begin
                                pend_next[PEND_RX] = 1'b1;
                                irq                = 1'b1;
                            end
                        end else begin
                            if (ien_reg[IER_TX]) begin
                                pend_next[PEND_TX] = 1'b1;
                                irq                = 1'b1;
                            end
                            if (ien_reg[IER_LSR]) begin
                                pend_next[PEND_LSR] = 1'b1;
                                irq                 = 1'b1;
                            end
                            result.tx_valid = 1'b1;
                            result.tx_byte  = masked;
                        end
                    end
                    OFS_IER: begin
                        if (dlab) begin
                            divisor_next[15:8]    = data_byte;
                            result.config_touched = TOUCH_DIV;
                        end else begin
                            ien_next              = data_byte;
                            result.config_touched = TOUCH_IER;
                        end
                    end
                    OFS_LCR: begin
                        lcr_next              = data_byte;
                        result.config_touched = TOUCH_LCR;
                    end
                    OFS_MCR: begin
                        mcr_next              = data_byte;
                        result.config_touched = TOUCH_MCR;
                    end
                    default: ;
                endcase
            end
            CMD_RX: begin
                rx_byte_next = data_byte;
                rx_full_next = 1'b1;
                if (ien_reg[IER_RX]) begin
                    pend_next[PEND_RX] = 1'b1;
                    irq                = 1'b1;
                end
            end
            default: ;
        endcase

        result.irq_raise = irq;
        result.rx_empty  = ~rx_full_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg  <= DIV_RESET;
            ien_reg      <= 8'h00;
            lcr_reg      <= 8'h00;
            mcr_reg      <= 8'h00;
            msr_reg      <= MSR_RESET;
            msr_last_reg <= 8'h00;
            pend_reg     <= 4'd0;
            rx_full_reg  <= 1'b0;
            rx_byte_reg  <= 8'h00;
        end else if (step_en) begin
            divisor_reg  <= divisor_next;
            ien_reg      <= ien_next;
            lcr_reg      <= lcr_next;
            mcr_reg      <= mcr_next;
            msr_last_reg <= msr_last_next;
            pend_reg     <= pend_next;
            rx_full_reg  <= rx_full_next;
            rx_byte_reg  <= rx_byte_next;
        end
    end

endmodule

// File: hdl/uart_8250_register_file.sv
// Usage notes for the UART register block.
//
// Input channel s_*: one item per handshake (s_valid & s_ready), carrying
// s_cmd (read, write, receive byte), s_reg_offset and s_data_byte.
// Result channel m_*: exactly one result item per input item, in order.
//
// An accepted item waits in the input register until it can hand off;
// the register update and the result are formed in the hand-off cycle and
// land in the output register at the next edge, so m_valid rises as the
// item leaves the input register. One item per cycle is sustained while
// the receiver keeps up: the input register hands off whenever the output
// register is empty or being taken, and the state updates in that same cycle.
//
// When the receiver holds m_ready low the result stays in the output
// register, the item behind it waits in the input register, and s_ready
// drops once both are full. Nothing is lost or repeated.
//
// Reset (aresetn low at a clock edge) empties both registers and loads
// the UART registers: divisor 12, modem status 0x30, everything else zero.
// Depends on urf_pkg and urf_core.
module uart_8250_register_file
    import urf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [2:0] s_reg_offset,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_irq_raise,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic [2:0] m_config_touched,
    output logic       m_rx_taken,
    output logic       m_rx_empty
);

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [2:0]  in_offset_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;
    urf_result_t out_reg;
    urf_result_t step_result;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    urf_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .cmd        (in_cmd_reg),
        .reg_offset (in_offset_reg),
        .data_byte  (in_data_reg),
        .result     (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= s_cmd;
            in_offset_reg <= s_reg_offset;
            in_data_reg   <= s_data_byte;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_data      = out_reg.read_data;
    assign m_irq_raise      = out_reg.irq_raise;
    assign m_tx_valid       = out_reg.tx_valid;
    assign m_tx_byte        = out_reg.tx_byte;
    assign m_config_touched = out_reg.config_touched;
    assign m_rx_taken       = out_reg.rx_taken;
    assign m_rx_empty       = out_reg.rx_empty;

endmodule

// File: hdl/urf_checker.sv
// Port-level checks for the UART register block, bound to its top level.
// Depends on urf_pkg and uart_8250_register_file_assert.svh.
`include "uart_8250_register_file_assert.svh"

module urf_checker
    import urf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_cmd,
    input logic [2:0] s_reg_offset,
    input logic [7:0] s_data_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_irq_raise,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic [2:0] m_config_touched,
    input logic       m_rx_taken,
    input logic       m_rx_empty
);

    logic        stalled;
    logic [22:0] payload;
    logic        cfg_write;
    logic        side_effects;

    assign stalled      = m_valid && !m_ready;
    assign payload      = {m_read_data, m_irq_raise, m_tx_valid, m_tx_byte,
                           m_config_touched, m_rx_taken, m_rx_empty};
    assign cfg_write    = m_valid && (m_config_touched != TOUCH_NONE);
    assign side_effects = (m_read_data != 8'h00) || m_tx_valid || m_rx_taken;

    // a stalled result holds
    `URF_ASSERT(a_result_held, stalled |=> m_valid && $stable(payload), "result changed while stalled")

    // no byte on the line means a zero byte field
    `URF_ASSERT(a_tx_byte_zero, m_valid && !m_tx_valid |-> m_tx_byte == '0, "stray tx_byte")

    // reading the receive buffer always frees it
    `URF_ASSERT(a_taken_empty, m_valid && m_rx_taken |-> m_rx_empty, "buffer full after host read")

    // a config write is never a read or a transmit
    `URF_ASSERT(a_config_write_only, cfg_write |-> !side_effects, "config write shows read or tx")

    // no result appears right after reset
    `URF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind uart_8250_register_file urf_checker u_urf_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for uart_8250_register_file: queue-fed driver, clocked monitor,
// in-bench register model predicting one result per item.
// Depends on urf_pkg and the RTL of uart_8250_register_file.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import urf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         WDOG_LIMIT = 2000;
    localparam int         HOLD_LEN   = 50;
    localparam int         PHASE_ITEMS = 125;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] off;
        logic [7:0] data;
    } bus_item_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd        = '0;
    logic [2:0] s_reg_offset = '0;
    logic [7:0] s_data_byte  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_irq_raise;
    logic       m_tx_valid;
    logic [7:0] m_tx_byte;
    logic [2:0] m_config_touched;
    logic       m_rx_taken;
    logic       m_rx_empty;

    uart_8250_register_file DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_reg_offset    (s_reg_offset),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq_raise     (m_irq_raise),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_config_touched(m_config_touched),
        .m_rx_taken      (m_rx_taken),
        .m_rx_empty      (m_rx_empty)
    );

    always #6 aclk = ~aclk;

    // register model state
    logic [15:0] div_q;
    logic [7:0]  ien_q, lcr_q, mcr_q, msr_q, msr_seen_q, rxb_q;
    logic [3:0]  pend_q;
    logic        rxf_q;

    bus_item_t   bus_items[$];
    urf_result_t pending_replies[$];
    bus_item_t   cur_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int err_count      = 0;
    int items_sent     = 0;
    int results_checked = 0;
    int idle_cycles    = 0;

    // receive buffer load, from the line or from loopback
    function automatic logic rx_load(input logic [7:0] b);
        rxb_q = b;
        rxf_q = 1'b1;
        if (ien_q[IER_RX]) begin
            pend_q[PEND_RX] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic urf_result_t uart_step(input bus_item_t it);
        urf_result_t r;
        logic [7:0]  t;
        logic [7:0]  diff;
        r = '0;
        case (it.cmd)
            CMD_READ: begin
                case (it.off)
                    OFS_DATA: begin
                        if (lcr_q[LCR_DLAB]) begin
                            r.read_data = div_q[7:0];
                        end else begin
                            rxf_q = 1'b0;
                            pend_q[PEND_RX] = 1'b0;
                            if (ien_q[IER_LSR]) begin
                                pend_q[PEND_LSR] = 1'b1;
                                r.irq_raise = 1'b1;
                            end
                            r.read_data = rxb_q;
                            r.rx_taken = 1'b1;
                        end
                    end
                    OFS_IER: r.read_data = lcr_q[LCR_DLAB] ? div_q[15:8] : ien_q;
                    OFS_IIR: begin
                        r.read_data = (pend_q == '0) ? IIR_NONE : 8'h00;
                        // TX is cleared by the read; MSR alone gives no id
                        if (pend_q[PEND_TX]) begin
                            r.read_data |= IIR_TX;
                            pend_q[PEND_TX] = 1'b0;
                        end else if (pend_q[PEND_RX]) begin
                            r.read_data |= IIR_RX;
                        end else if (pend_q[PEND_LSR]) begin
                            r.read_data |= IIR_LSR;
                        end
                        if (pend_q != '0) r.irq_raise = 1'b1;
                    end
                    OFS_LCR: r.read_data = lcr_q;
                    OFS_MCR: r.read_data = mcr_q;
                    OFS_LSR: begin
                        pend_q[PEND_LSR] = 1'b0;
                        r.read_data = rxf_q ? LSR_DATA : LSR_EMPTY;
                    end
                    OFS_MSR: begin
                        diff = msr_q ^ msr_seen_q;
                        r.read_data = {msr_q[7:4], diff[7], 1'b0, diff[5], diff[4]};
                        msr_seen_q = msr_q;
                        pend_q[PEND_MSR] = 1'b0;
                    end
                    default: r.read_data = UNMAPPED;
                endcase
            end
            CMD_WRITE: begin
                case (it.off)
                    OFS_DATA: begin
                        if (lcr_q[LCR_DLAB]) begin
                            div_q[7:0] = it.data;
                            r.config_touched = TOUCH_DIV;
                        end else begin
                            // LCR[1:0] selects 5..8 data bits
                            t = it.data & (8'hFF >> (2'd3 - lcr_q[1:0]));
                            if (mcr_q[MCR_LOOP]) begin
                                r.irq_raise = rx_load(t);
                            end else begin
                                if (ien_q[IER_TX]) begin
                                    pend_q[PEND_TX] = 1'b1;
                                    r.irq_raise = 1'b1;
                                end
                                if (ien_q[IER_LSR]) begin
                                    pend_q[PEND_LSR] = 1'b1;
                                    r.irq_raise = 1'b1;
                                end
                                r.tx_valid = 1'b1;
                                r.tx_byte = t;
                            end
                        end
                    end
                    OFS_IER: begin
                        if (lcr_q[LCR_DLAB]) begin
                            div_q[15:8] = it.data;
                            r.config_touched = TOUCH_DIV;
                        end else begin
                            ien_q = it.data;
                            r.config_touched = TOUCH_IER;
                        end
                    end
                    OFS_LCR: begin
                        lcr_q = it.data;
                        r.config_touched = TOUCH_LCR;
                    end
                    OFS_MCR: begin
                        mcr_q = it.data;
                        r.config_touched = TOUCH_MCR;
                    end
                    default: ;
                endcase
            end
            CMD_RX: r.irq_raise = rx_load(it.data);
            default: ;
        endcase
        r.rx_empty = ~rxf_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic queue_item(input logic [1:0] cmd, input logic [2:0] off,
                              input logic [7:0] data);
        bus_item_t it;
        it.cmd  = cmd;
        it.off  = off;
        it.data = data;
        bus_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (bus_items.size() != 0 || s_valid || pending_replies.size() != 0)
            @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_replies.push_back(uart_step(cur_item));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (bus_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = bus_items.pop_front();
                    s_valid      <= 1'b1;
                    s_cmd        <= cur_item.cmd;
                    s_reg_offset <= cur_item.off;
                    s_data_byte  <= cur_item.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver pacing
    always @(posedge aclk) begin
        urf_result_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_read_data, m_irq_raise, m_tx_valid, m_tx_byte,
                       m_config_touched, m_rx_taken, m_rx_empty};
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected result item", 16'(got), 16'h0);
                end else begin
                    want = pending_replies.pop_front();
                    results_checked++;
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", 16'(got.read_data),
                                        16'(want.read_data));
                    if (got.irq_raise !== want.irq_raise)
                        report_mismatch("irq_raise", 16'(got.irq_raise),
                                        16'(want.irq_raise));
                    if (got.tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", 16'(got.tx_valid),
                                        16'(want.tx_valid));
                    if (got.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
                    if (got.config_touched !== want.config_touched)
                        report_mismatch("config_touched", 16'(got.config_touched),
                                        16'(want.config_touched));
                    if (got.rx_taken !== want.rx_taken)
                        report_mismatch("rx_taken", 16'(got.rx_taken),
                                        16'(want.rx_taken));
                    if (got.rx_empty !== want.rx_empty)
                        report_mismatch("rx_empty", 16'(got.rx_empty),
                                        16'(want.rx_empty));
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int send_pct[4];
        int recv_pct[4];
        int r;
        logic [1:0] cmd;
        send_pct = '{0, 52, 0, 9};
        recv_pct = '{0, 0, 52, 9};

        div_q      = DIV_RESET;
        ien_q      = '0;
        lcr_q      = '0;
        mcr_q      = '0;
        msr_q      = MSR_RESET;
        msr_seen_q = '0;
        pend_q     = '0;
        rxf_q      = 1'b0;
        rxb_q      = '0;

        // directed: first MSR read shows deltas, then none
        queue_item(CMD_READ,   OFS_MSR,  8'h00);
        queue_item(CMD_READ,   OFS_MSR,  8'h00);
        queue_item(CMD_READ,   OFS_IIR,  8'h00);
        queue_item(CMD_READ,   OFS_LSR,  8'h00);
        queue_item(CMD_READ,   OFS_SCR,  8'h00);
        queue_item(CMD_WRITE,  OFS_SCR,  8'hFF);
        queue_item(CMD_WRITE,  OFS_IIR,  8'hAA);
        queue_item(CMD_UNUSED, OFS_SCR,  8'hFF);
        queue_item(CMD_WRITE,  OFS_LCR,  8'h80);
        queue_item(CMD_WRITE,  OFS_DATA, 8'hFF);
        queue_item(CMD_WRITE,  OFS_IER,  8'h00);
        queue_item(CMD_READ,   OFS_DATA, 8'h00);
        queue_item(CMD_READ,   OFS_IER,  8'h00);
        queue_item(CMD_WRITE,  OFS_LCR,  8'h03);
        queue_item(CMD_WRITE,  OFS_IER,  8'h07);
        queue_item(CMD_WRITE,  OFS_DATA, 8'hA5);
        queue_item(CMD_READ,   OFS_IIR,  8'h00);
        queue_item(CMD_READ,   OFS_IIR,  8'h00);
        queue_item(CMD_RX,     OFS_DATA, 8'h5A);
        queue_item(CMD_RX,     OFS_DATA, 8'hC3);
        queue_item(CMD_READ,   OFS_IIR,  8'h00);
        queue_item(CMD_READ,   OFS_DATA, 8'h00);
        queue_item(CMD_WRITE,  OFS_LCR,  8'h00);
        queue_item(CMD_WRITE,  OFS_MCR,  8'h10);
        queue_item(CMD_WRITE,  OFS_DATA, 8'hFF);
        queue_item(CMD_READ,   OFS_LSR,  8'h00);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            // long receiver hold-off while the sender keeps offering
            if (ph == 0) hold_req++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(99);
                cmd = (r < 40) ? CMD_READ : (r < 75) ? CMD_WRITE :
                      (r < 97) ? CMD_RX : CMD_UNUSED;
                queue_item(cmd, 3'($urandom_range(7)), 8'($urandom_range(255)));
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Ran %0d items (reads, writes, line bytes, unused commands) under",
                 items_sent);
        $display("four pacing phases and a long receiver hold; %0d results checked.",
                 results_checked);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/urf_pkg.sv
hdl/urf_core.sv
hdl/uart_8250_register_file.sv
hdl/urf_checker.sv
bench/testbench.sv
